FILE: src/weighted_nearest_point_search_defines.svh
// Assertion macros shared by the weighted nearest point search checkers.
`ifndef WEIGHTED_NEAREST_POINT_SEARCH_DEFINES_SVH
`define WEIGHTED_NEAREST_POINT_SEARCH_DEFINES_SVH

// Clocked property that is switched off while reset is asserted.
`define WNPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold at every edge, reset included.
`define WNPS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wnps_pkg.sv
// Shared types and constants of the weighted nearest point search.
`timescale 1ns / 1ps
package wnps_pkg;

  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned CoordBitsDef    = 24;

  localparam int unsigned InCoordW  = 24;
  localparam int unsigned AngleW    = 9;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned DivisorW  = 23;
  localparam int unsigned IndexW    = 10;
  localparam int unsigned ProdW     = InCoordW + WeightW;
  // Wide enough for any entry count up to the largest supported table.
  localparam int unsigned ExtIndexW = 17;
  localparam int unsigned AngleFull = 360;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_WEIGHT_X      = 3'd0,
    REG_WEIGHT_Y      = 3'd1,
    REG_WEIGHT_ANGLE  = 3'd2,
    REG_LAYOUT_WIDTH  = 3'd3,
    REG_LAYOUT_HEIGHT = 3'd4
  } reg_e;

  // Write controls of the point table.
  typedef struct packed {
    logic entry_we;
    logic valid_we;
    logic valid_bit;
  } store_wr_t;

endpackage

FILE: src/weighted_nearest_point_search.sv
// Top level of the weighted nearest point search with its sequencer and distance pipeline.
//
// The block keeps a table of up to TABLE_ENTRIES path points and answers one request at a
// time. An insert scales x, y and both angles through a single shared multiply-and-divide
// unit and stores the point under the next free index. A remove skips the scaler. A query
// scales its x, y and four angle variants through the same unit and then sweeps the table
// four times, once per angle variant, reading one entry per cycle from the table's single
// read port; each sweep reads every entry inserted since reset. The table itself is never
// cleared: the insert count marks which entries have been written, so there is no start-up
// pass. Ties go to the earlier variant, then to the lower entry, then to the first angle of
// an entry. A result waits in an output register while the next request is taken; op code
// 3 is taken and dropped.
`timescale 1ns / 1ps
module weighted_nearest_point_search #(
  parameter int unsigned TABLE_ENTRIES = wnps_pkg::TableEntriesDef,
  parameter int unsigned COORD_BITS    = wnps_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic signed [wnps_pkg::InCoordW-1:0] x_pos_i,
  input  logic signed [wnps_pkg::InCoordW-1:0] y_pos_i,
  input  logic [wnps_pkg::AngleW-1:0]          angle_first_i,
  input  logic [wnps_pkg::AngleW-1:0]          angle_second_i,
  input  logic [wnps_pkg::IndexW-1:0]          entry_index_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic [wnps_pkg::IndexW-1:0]          point_index_o,
  output logic                                 found_o,
  // Register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wnps_pkg::ApbAddrW-1:0]        paddr,
  input  logic [wnps_pkg::ApbDataW-1:0]        pwdata,
  output logic [wnps_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EXT_W = wnps_pkg::ExtIndexW;
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * CB + 1;
  localparam int unsigned MW    = 2 * CB + 2;
  localparam int unsigned DW    = 2 * CB + 3;
  localparam int unsigned ICW   = wnps_pkg::InCoordW;
  localparam int unsigned WW    = wnps_pkg::WeightW;
  localparam int unsigned DVW   = wnps_pkg::DivisorW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE_GO, S_SCALE_WAIT, S_COMMIT, S_SCAN, S_DRAIN, S_DONE
  } state_e;

  // Register file
  logic signed [WW-1:0] weight_x_q, weight_y_q, weight_angle_q;
  logic [DVW-1:0]       layout_width_q, layout_height_q;
  logic                 cfg_we;

  // Sequencer
  state_e               state_q;
  logic [1:0]           op_q;
  logic signed [ICW-1:0] x_in_q, y_in_q;
  logic [wnps_pkg::AngleW-1:0] a1_q, a2_q;
  logic [2:0]           job_q;
  logic [CNT_W-1:0]     nf_q;
  logic signed [CB-1:0] sx_q, sy_q;
  logic signed [CB-1:0] var_q [4];
  logic [1:0]           v_q;
  logic [CNT_W-1:0]     e_q;

  // Distance pipeline
  logic                 p0_vld_q, p1_vld_q, p2_vld_q;
  logic [IDX_W-1:0]     p0_e_q, p1_e_q, p2_e_q;
  logic [1:0]           p0_v_q;
  logic signed [CB:0]   dx_q, dy_q, da_q, db_q;
  logic [SQ_W-1:0]      sqx_q, sqy_q, sqa_q, sqb_q;
  logic                 have_q;
  logic [DW-1:0]        best_q;
  logic [IDX_W-1:0]     best_e_q;

  // Result and output registers
  logic [1:0]           res_status_q;
  logic [wnps_pkg::IndexW-1:0] res_idx_q;
  logic                 res_found_q;
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [wnps_pkg::IndexW-1:0] out_idx_q;
  logic                 out_found_q;

  // Shared scaler
  logic                 scl_start, scl_done;
  logic signed [ICW-1:0] scl_val;
  logic signed [WW-1:0] scl_wt;
  logic [DVW-1:0]       scl_div;
  logic signed [CB-1:0] scl_res;

  // Table ports
  wnps_pkg::store_wr_t  st_wr;
  logic [IDX_W-1:0]     st_waddr;
  logic signed [CB-1:0] rd_x, rd_y, rd_a, rd_b;
  logic                 rd_valid;

  logic                 in_accept;
  logic                 table_full;
  logic [EXT_W-1:0]     eidx_ext;
  logic                 eidx_ok;
  logic [2:0]           last_job;
  logic [CNT_W-1:0]     e_next;
  logic [wnps_pkg::AngleW-1:0] a_max, a_min;
  logic signed [CB-1:0] var_cur;
  logic [DW-1:0]        dist_a, dist_b;
  logic                 take_a, take_b;
  logic [DW-1:0]        best_mid;
  logic                 out_free;

  // ---------------------------------------------------------------------------------------
  // Register port: writes complete in the access phase, reads are combinational.
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_x_q      <= WW'(1);
      weight_y_q      <= WW'(1);
      weight_angle_q  <= WW'(1);
      layout_width_q  <= DVW'(1);
      layout_height_q <= DVW'(1);
    end else if (cfg_we) begin
      case (paddr[4:2])
        wnps_pkg::REG_WEIGHT_X:      weight_x_q      <= pwdata[WW-1:0];
        wnps_pkg::REG_WEIGHT_Y:      weight_y_q      <= pwdata[WW-1:0];
        wnps_pkg::REG_WEIGHT_ANGLE:  weight_angle_q  <= pwdata[WW-1:0];
        wnps_pkg::REG_LAYOUT_WIDTH:  layout_width_q  <= pwdata[DVW-1:0];
        wnps_pkg::REG_LAYOUT_HEIGHT: layout_height_q <= pwdata[DVW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      wnps_pkg::REG_WEIGHT_X:      prdata = wnps_pkg::ApbDataW'($unsigned(weight_x_q));
      wnps_pkg::REG_WEIGHT_Y:      prdata = wnps_pkg::ApbDataW'($unsigned(weight_y_q));
      wnps_pkg::REG_WEIGHT_ANGLE:  prdata = wnps_pkg::ApbDataW'($unsigned(weight_angle_q));
      wnps_pkg::REG_LAYOUT_WIDTH:  prdata = wnps_pkg::ApbDataW'(layout_width_q);
      wnps_pkg::REG_LAYOUT_HEIGHT: prdata = wnps_pkg::ApbDataW'(layout_height_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Request decode.
  // ---------------------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign table_full = (nf_q == CNT_W'(TABLE_ENTRIES));
  assign eidx_ext   = EXT_W'(entry_index_i);
  // A remove only touches entries that have been written since reset.
  assign eidx_ok    = (eidx_ext < EXT_W'(nf_q));
  assign last_job   = (op_q == wnps_pkg::OP_INSERT) ? 3'd3 : 3'd5;
  assign a_max      = (a1_q > a2_q) ? a1_q : a2_q;
  assign a_min      = (a1_q < a2_q) ? a1_q : a2_q;

  // Operands of the shared scaler: x, y, both angles, then the two wrapped variants.
  always_comb begin
    scl_wt  = weight_angle_q;
    scl_div = DVW'(wnps_pkg::AngleFull);
    case (job_q)
      3'd0: begin
        scl_val = x_in_q;
        scl_wt  = weight_x_q;
        scl_div = layout_width_q;
      end
      3'd1: begin
        scl_val = y_in_q;
        scl_wt  = weight_y_q;
        scl_div = layout_height_q;
      end
      3'd2:    scl_val = ICW'(a1_q);
      3'd3:    scl_val = ICW'(a2_q);
      3'd4:    scl_val = ICW'(a_max) - ICW'(wnps_pkg::AngleFull);
      3'd5:    scl_val = ICW'(a_min) + ICW'(wnps_pkg::AngleFull);
      default: scl_val = '0;
    endcase
  end

  assign scl_start = (state_q == S_SCALE_GO);

  wnps_scaler #(
    .COORD_BITS (COORD_BITS)
  ) u_scaler (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scl_start),
    .value_i   (scl_val),
    .weight_i  (scl_wt),
    .divisor_i (scl_div),
    .done_o    (scl_done),
    .result_o  (scl_res)
  );

  // ---------------------------------------------------------------------------------------
  // Table writes: a remove clears the flag as it is taken, an insert commits after scaling.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    st_wr    = '0;
    st_waddr = nf_q[IDX_W-1:0];
    if (state_q == S_COMMIT && op_q == wnps_pkg::OP_INSERT) begin
      st_wr.entry_we  = 1'b1;
      st_wr.valid_we  = 1'b1;
      st_wr.valid_bit = 1'b1;
    end else if (in_accept && op_i == wnps_pkg::OP_REMOVE && eidx_ok) begin
      st_wr.valid_we = 1'b1;
      st_waddr       = eidx_ext[IDX_W-1:0];
    end
  end

  wnps_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COORD_BITS    (COORD_BITS),
    .IDX_W         (IDX_W)
  ) u_store (
    .clk_i    (clk_i),
    .wr_i     (st_wr),
    .waddr_i  (st_waddr),
    .wx_i     (sx_q),
    .wy_i     (sy_q),
    .wa_i     (var_q[0]),
    .wb_i     (var_q[1]),
    .raddr_i  (e_q[IDX_W-1:0]),
    .rx_o     (rd_x),
    .ry_o     (rd_y),
    .ra_o     (rd_a),
    .rb_o     (rd_b),
    .rvalid_o (rd_valid)
  );

  // ---------------------------------------------------------------------------------------
  // Distance pipeline: table read, differences, squares, then sum and compare.
  // Within one entry the first angle is tried before the second.
  // ---------------------------------------------------------------------------------------
  assign e_next  = e_q + CNT_W'(1);
  assign var_cur = var_q[p0_v_q];
  assign dist_a  = DW'(sqx_q) + DW'(sqy_q) + DW'(sqa_q);
  assign dist_b  = DW'(sqx_q) + DW'(sqy_q) + DW'(sqb_q);
  assign take_a  = !have_q || (dist_a < best_q);
  assign best_mid = take_a ? dist_a : best_q;
  assign take_b  = (dist_b < best_mid);

  always_ff @(posedge clk_i) begin
    p0_e_q <= e_q[IDX_W-1:0];
    p0_v_q <= v_q;
    p1_e_q <= p0_e_q;
    dx_q   <= $signed({sx_q[CB-1], sx_q}) - $signed({rd_x[CB-1], rd_x});
    dy_q   <= $signed({sy_q[CB-1], sy_q}) - $signed({rd_y[CB-1], rd_y});
    da_q   <= $signed({var_cur[CB-1], var_cur}) - $signed({rd_a[CB-1], rd_a});
    db_q   <= $signed({var_cur[CB-1], var_cur}) - $signed({rd_b[CB-1], rd_b});
    p2_e_q <= p1_e_q;
    // The squares are formed at full width so that no high bits are lost.
    sqx_q  <= SQ_W'($unsigned(MW'(dx_q) * MW'(dx_q)));
    sqy_q  <= SQ_W'($unsigned(MW'(dy_q) * MW'(dy_q)));
    sqa_q  <= SQ_W'($unsigned(MW'(da_q) * MW'(da_q)));
    sqb_q  <= SQ_W'($unsigned(MW'(db_q) * MW'(db_q)));
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer, best-match tracking and output register.
  // ---------------------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nf_q        <= '0;
      job_q       <= '0;
      v_q         <= '0;
      e_q         <= '0;
      p0_vld_q    <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p0_vld_q <= (state_q == S_SCAN);
      p1_vld_q <= p0_vld_q && rd_valid;
      p2_vld_q <= p1_vld_q;

      if (p2_vld_q) begin
        if (take_b) begin
          best_q   <= dist_b;
          best_e_q <= p2_e_q;
        end else if (take_a) begin
          best_q   <= dist_a;
          best_e_q <= p2_e_q;
        end
        have_q <= 1'b1;
      end

      // A new result in the done state takes over the output register instead.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q   <= op_i;
            x_in_q <= x_pos_i;
            y_in_q <= y_pos_i;
            a1_q   <= angle_first_i;
            a2_q   <= angle_second_i;
            job_q  <= '0;
            case (op_i)
              wnps_pkg::OP_INSERT: begin
                if (table_full) begin
                  res_status_q <= wnps_pkg::ST_FULL;
                  res_idx_q    <= '0;
                  res_found_q  <= 1'b0;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_SCALE_GO;
                end
              end
              wnps_pkg::OP_REMOVE: begin
                res_status_q <= eidx_ok ? wnps_pkg::ST_OK : wnps_pkg::ST_BAD_INDEX;
                res_idx_q    <= entry_index_i;
                res_found_q  <= 1'b0;
                state_q      <= S_DONE;
              end
              wnps_pkg::OP_QUERY: state_q <= S_SCALE_GO;
              default: ;
            endcase
          end
        end
        S_SCALE_GO: state_q <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (scl_done) begin
            case (job_q)
              3'd0:    sx_q <= scl_res;
              3'd1:    sy_q <= scl_res;
              3'd2:    var_q[0] <= scl_res;
              3'd3:    var_q[1] <= scl_res;
              3'd4:    var_q[2] <= scl_res;
              3'd5:    var_q[3] <= scl_res;
              default: ;
            endcase
            job_q   <= job_q + 3'd1;
            state_q <= (job_q == last_job) ? S_COMMIT : S_SCALE_GO;
          end
        end
        S_COMMIT: begin
          res_found_q <= 1'b0;
          if (op_q == wnps_pkg::OP_INSERT) begin
            res_status_q <= wnps_pkg::ST_OK;
            res_idx_q    <= wnps_pkg::IndexW'(EXT_W'(nf_q));
            nf_q         <= nf_q + CNT_W'(1);
            state_q      <= S_DONE;
          end else if (nf_q == '0) begin
            res_status_q <= wnps_pkg::ST_EMPTY;
            res_idx_q    <= '0;
            state_q      <= S_DONE;
          end else begin
            have_q  <= 1'b0;
            v_q     <= '0;
            e_q     <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Variants form the outer sweep and entries the inner one.
          if (e_next == nf_q) begin
            e_q <= '0;
            if (v_q == 2'd3) begin
              state_q <= S_DRAIN;
            end else begin
              v_q <= v_q + 2'd1;
            end
          end else begin
            e_q <= e_next;
          end
        end
        S_DRAIN: begin
          if (!p0_vld_q && !p1_vld_q && !p2_vld_q) begin
            res_status_q <= have_q ? wnps_pkg::ST_OK : wnps_pkg::ST_EMPTY;
            res_idx_q    <= have_q ? wnps_pkg::IndexW'(EXT_W'(best_e_q)) : '0;
            res_found_q  <= have_q;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_idx_q    <= res_idx_q;
            out_found_q  <= res_found_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign point_index_o = out_idx_q;
  assign found_o       = out_found_q;

endmodule

FILE: src/wnps_scaler.sv
// Shared scaling unit: multiply by a weight, divide one bit per cycle, saturate.
`timescale 1ns / 1ps
module wnps_scaler #(
  parameter int unsigned COORD_BITS = wnps_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [wnps_pkg::InCoordW-1:0] value_i,
  input  logic signed [wnps_pkg::WeightW-1:0]  weight_i,
  input  logic [wnps_pkg::DivisorW-1:0]        divisor_i,
  output logic                                done_o,
  output logic signed [COORD_BITS-1:0]        result_o
);

  localparam int unsigned PW    = wnps_pkg::ProdW;
  localparam int unsigned DV    = wnps_pkg::DivisorW;
  localparam int unsigned CNT_W = $clog2(PW + 1);
  localparam logic signed [PW:0] SatHi = (PW + 1)'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [PW:0] SatLo = -SatHi - (PW + 1)'(1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_e;

  state_e                     state_q;
  logic signed [wnps_pkg::InCoordW-1:0] val_q;
  logic signed [wnps_pkg::WeightW-1:0]  wt_q;
  logic [DV-1:0]              div_q;
  logic                       neg_q;
  logic [PW-1:0]              mag_q;
  logic [DV-1:0]              rem_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       done_q;
  logic signed [COORD_BITS-1:0] res_q;

  logic signed [PW-1:0] prod;
  logic [DV:0]          trial;
  logic [DV:0]          diff;
  logic                 ge;
  logic signed [PW:0]   quot_s;

  assign prod   = val_q * wt_q;
  assign trial  = {rem_q, mag_q[PW-1]};
  assign diff   = trial - {1'b0, div_q};
  assign ge     = (trial >= {1'b0, div_q});
  assign quot_s = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            val_q   <= value_i;
            wt_q    <= weight_i;
            // A zero divisor behaves as one.
            div_q   <= (divisor_i == '0) ? DV'(1) : divisor_i;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          neg_q   <= prod[PW-1];
          mag_q   <= prod[PW-1] ? PW'(-prod) : PW'(prod);
          rem_q   <= '0;
          cnt_q   <= CNT_W'(PW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q <= ge ? diff[DV-1:0] : trial[DV-1:0];
          mag_q <= {mag_q[PW-2:0], ge};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (quot_s > SatHi) begin
            res_q <= SatHi[COORD_BITS-1:0];
          end else if (quot_s < SatLo) begin
            res_q <= SatLo[COORD_BITS-1:0];
          end else begin
            res_q <= quot_s[COORD_BITS-1:0];
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: src/wnps_store.sv
// Point table: scaled coordinates, two scaled angles and a valid flag per entry.
`timescale 1ns / 1ps
module wnps_store #(
  parameter int unsigned TABLE_ENTRIES = wnps_pkg::TableEntriesDef,
  parameter int unsigned COORD_BITS    = wnps_pkg::CoordBitsDef,
  parameter int unsigned IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic                         clk_i,
  input  wnps_pkg::store_wr_t          wr_i,
  input  logic [IDX_W-1:0]             waddr_i,
  input  logic signed [COORD_BITS-1:0] wx_i,
  input  logic signed [COORD_BITS-1:0] wy_i,
  input  logic signed [COORD_BITS-1:0] wa_i,
  input  logic signed [COORD_BITS-1:0] wb_i,
  input  logic [IDX_W-1:0]             raddr_i,
  output logic signed [COORD_BITS-1:0] rx_o,
  output logic signed [COORD_BITS-1:0] ry_o,
  output logic signed [COORD_BITS-1:0] ra_o,
  output logic signed [COORD_BITS-1:0] rb_o,
  output logic                         rvalid_o
);

  logic [4*COORD_BITS-1:0] point_mem [TABLE_ENTRIES];
  logic                    valid_mem [TABLE_ENTRIES];
  logic [4*COORD_BITS-1:0] point_q;
  logic                    valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.entry_we) begin
      point_mem[waddr_i] <= {wx_i, wy_i, wa_i, wb_i};
    end
    point_q <= point_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid_we) begin
      valid_mem[waddr_i] <= wr_i.valid_bit;
    end
    valid_q <= valid_mem[raddr_i];
  end

  assign rx_o     = point_q[4*COORD_BITS-1:3*COORD_BITS];
  assign ry_o     = point_q[3*COORD_BITS-1:2*COORD_BITS];
  assign ra_o     = point_q[2*COORD_BITS-1:COORD_BITS];
  assign rb_o     = point_q[COORD_BITS-1:0];
  assign rvalid_o = valid_q;

endmodule

FILE: src/wnps_checker.sv
// Port-level checks of the weighted nearest point search and their binding.
`timescale 1ns / 1ps
`include "weighted_nearest_point_search_defines.svh"
module wnps_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  status_o,
  input logic [wnps_pkg::IndexW-1:0] point_index_o,
  input logic                        found_o,
  input logic                        pready
);

  `WNPS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(point_index_o) && $stable(found_o), "stalled result changed")
  `WNPS_ASSERT(a_found_ok, clk_i, rst_ni, out_valid_o && found_o |-> status_o == wnps_pkg::ST_OK, "found result without ok status")
  `WNPS_ASSERT(a_miss_zero, clk_i, rst_ni, out_valid_o && (status_o == wnps_pkg::ST_FULL || status_o == wnps_pkg::ST_EMPTY) |-> point_index_o == '0 && !found_o, "failed result carries an index")
  `WNPS_ASSERT_ALWAYS(a_pready, clk_i, pready == 1'b1, "register port not ready")

endmodule

bind weighted_nearest_point_search wnps_checker u_wnps_checker (.*);
